// File: sv/assert_macros.svh
// assertion macros shared by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define JFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define JFP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: sv/jfp_pkg.sv
// types, codes and character constants of the fuse stream parser
package jfp_pkg;

   localparam int MAX_FUSES_DEF = 65536;
   localparam int BYTE_W        = 8;
   localparam int EVENT_W       = 3;
   localparam int ADDR_W        = 16;
   localparam int COUNT_W       = 17;

   // parse phase codes
   localparam logic [1:0] PH_WAIT  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_BODY  = 2'd2;

   // field kinds
   localparam logic [1:0] FK_OTHER = 2'd0;
   localparam logic [1:0] FK_Q     = 2'd1;
   localparam logic [1:0] FK_F     = 2'd2;
   localparam logic [1:0] FK_L     = 2'd3;

   // number scan phases
   localparam logic [2:0] NP_BEGIN  = 3'd0;
   localparam logic [2:0] NP_PRE    = 3'd1;
   localparam logic [2:0] NP_DIGITS = 3'd2;
   localparam logic [2:0] NP_AFTER  = 3'd3;
   localparam logic [2:0] NP_SIGN   = 3'd4;
   localparam logic [2:0] NP_IGNORE = 3'd5;

   // event codes
   localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
   localparam logic [EVENT_W-1:0] EV_COUNT = 3'd1;
   localparam logic [EVENT_W-1:0] EV_FILL  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_WRITE = 3'd3;
   localparam logic [EVENT_W-1:0] EV_DONE  = 3'd4;
   localparam logic [EVENT_W-1:0] EV_ERROR = 3'd5;

   // characters
   localparam logic [BYTE_W-1:0] CH_STX   = 8'h02;
   localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_Q     = 8'h51;
   localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
   localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;

   // decoded view of one input byte
   typedef struct packed {
      logic       is_stx;
      logic       is_etx;
      logic       is_space;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_star;
      logic       is_plus;
      logic       is_minus;
      logic       is_bit;
      logic       is_q;
      logic       is_f;
      logic       is_l;
   } char_class_type;

   // one result beat
   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [ADDR_W-1:0]  fuse_address;
      logic               fuse_value;
      logic [COUNT_W-1:0] fuse_count;
   } result_type;

endpackage

// File: sv/jedec_fuse_stream_parser.sv
// top level: jedec fuse text parser with input and result registers
//
//  channel | ports                                   | direction
//  req     | req_valid req_ready req_data_byte       | text byte in
//  rsp     | rsp_valid rsp_ready rsp_event_res ...   | one event beat per byte out
//
// one beat per byte, one byte per cycle sustained while rsp_ready holds; rsp valid
// after req accept via the input register, then parse logic into the result register.
// the state update of the parser is the only loop, closed through its state registers.
// reset clears the parser to waiting for STX and empties both registers.
// a stalled rsp holds its beat; req keeps flowing until both registers are full.
module jedec_fuse_stream_parser #(
   parameter int MAX_FUSES = jfp_pkg::MAX_FUSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [jfp_pkg::BYTE_W-1:0]      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [jfp_pkg::EVENT_W-1:0]     rsp_event_res,
   output logic [jfp_pkg::ADDR_W-1:0]      rsp_fuse_address,
   output logic                            rsp_fuse_value,
   output logic [jfp_pkg::COUNT_W-1:0]     rsp_fuse_count
);
   import jfp_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        rsp_ff;
   result_type        result;
   char_class_type    cls;
   logic              advance;
   logic              req_take;

   // handshake control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // byte decode
   jfp_char_class u_class (
      .data_byte (byte_ff),
      .cls       (cls)
   );

   // parser
   jfp_parse_core #(
      .MAX_FUSES (MAX_FUSES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .cls     (cls),
      .bit_val (byte_ff[0]),
      .result  (result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_data_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = rsp_ff.event_res;
   assign rsp_fuse_address = rsp_ff.fuse_address;
   assign rsp_fuse_value   = rsp_ff.fuse_value;
   assign rsp_fuse_count   = rsp_ff.fuse_count;

endmodule

// File: sv/jfp_char_class.sv
// byte decoder: classifies one text byte for the parser
module jfp_char_class (
   input  logic [jfp_pkg::BYTE_W-1:0] data_byte,
   output jfp_pkg::char_class_type    cls
);
   import jfp_pkg::*;

   // per-character flags
   always_comb begin
      cls.is_stx   = (data_byte == CH_STX);
      cls.is_etx   = (data_byte == CH_ETX);
      cls.is_space = (data_byte == CH_SPACE) ||
                     ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
      cls.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
      // low nibble of an ascii digit is its value
      cls.digit    = data_byte[3:0];
      cls.is_star  = (data_byte == CH_STAR);
      cls.is_plus  = (data_byte == CH_PLUS);
      cls.is_minus = (data_byte == CH_MINUS);
      cls.is_bit   = (data_byte == CH_ZERO) || (data_byte == CH_ONE);
      cls.is_q     = (data_byte == CH_Q);
      cls.is_f     = (data_byte == CH_F);
      cls.is_l     = (data_byte == CH_L);
   end

endmodule

// File: sv/jfp_parse_core.sv
// parser state and next-state logic, one byte per step
`include "assert_macros.svh"

module jfp_parse_core #(
   parameter int MAX_FUSES = jfp_pkg::MAX_FUSES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  jfp_pkg::char_class_type cls,
   input  logic                    bit_val,
   output jfp_pkg::result_type     result
);
   import jfp_pkg::*;

   localparam int CAP = MAX_FUSES + 1;
   localparam int AW  = $clog2(MAX_FUSES + 2);
   localparam int XW  = AW + 4;

   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    kind_ff, kind_in;
   logic [2:0]    nphase_ff, nphase_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] count_ff, count_in;
   logic          declared_ff, declared_in;
   logic [AW-1:0] baddr_ff, baddr_in;
   logic          failed_ff, failed_in;

   logic [XW-1:0]      acc_sum;
   logic [AW-1:0]      acc_next;
   logic               have_num;
   logic               fail;
   logic [EVENT_W-1:0] ev;
   logic [AW-1:0]      ev_addr;
   logic               ev_val;

   // decimal accumulate, saturating one above the fuse limit
   assign acc_sum  = XW'({acc_ff, 3'b000}) + XW'({acc_ff, 1'b0}) + XW'(cls.digit);
   assign acc_next = (acc_sum > XW'(CAP)) ? AW'(CAP) : AW'(acc_sum);
   assign have_num = (nphase_ff == NP_DIGITS) || (nphase_ff == NP_AFTER);

   // next state and event
   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      nphase_in   = nphase_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      declared_in = declared_ff;
      baddr_in    = baddr_ff;
      failed_in   = failed_ff;
      fail        = 1'b0;
      ev          = EV_NONE;
      ev_addr     = '0;
      ev_val      = 1'b0;

      unique case (phase_ff)
         PH_WAIT: begin
            if (cls.is_stx) begin
               phase_in    = PH_START;
               declared_in = 1'b0;
               count_in    = '0;
            end
         end
         PH_START: begin
            if (cls.is_etx) begin
               ev       = EV_DONE;
               phase_in = PH_WAIT;
            end else if (!cls.is_space) begin
               kind_in   = cls.is_q ? FK_Q : cls.is_f ? FK_F : cls.is_l ? FK_L : FK_OTHER;
               nphase_in = NP_BEGIN;
               acc_in    = '0;
               failed_in = 1'b0;
               phase_in  = PH_BODY;
               if (cls.is_l && !declared_ff) begin
                  fail = 1'b1;
               end
            end
         end
         PH_BODY: begin
            if (cls.is_star) begin
               // field end
               phase_in = PH_START;
               if (kind_ff == FK_Q && have_num) begin
                  if (declared_ff || acc_ff > AW'(MAX_FUSES)) begin
                     fail = 1'b1;
                  end else begin
                     count_in    = acc_ff;
                     declared_in = 1'b1;
                     ev          = EV_COUNT;
                  end
               end else if (kind_ff == FK_F) begin
                  if (declared_ff && have_num && acc_ff <= AW'(1) &&
                      !(failed_ff && acc_ff != '0)) begin
                     ev     = EV_FILL;
                     ev_val = acc_ff[0];
                  end else begin
                     fail = 1'b1;
                  end
               end else if (kind_ff == FK_L && !have_num) begin
                  fail = 1'b1;
               end else if (kind_ff == FK_L && nphase_ff == NP_DIGITS) begin
                  baddr_in = acc_ff;
               end
            end else begin
               unique case (kind_ff)
                  FK_Q: begin
                     if (nphase_ff == NP_BEGIN) begin
                        nphase_in = cls.is_f ? NP_PRE : NP_IGNORE;
                     end else if (nphase_ff == NP_PRE) begin
                        if (cls.is_digit) begin
                           nphase_in = NP_DIGITS;
                           acc_in    = acc_next;
                        end else if (!cls.is_space) begin
                           nphase_in = NP_IGNORE;
                        end
                     end else if (nphase_ff == NP_DIGITS) begin
                        if (cls.is_digit) acc_in = acc_next;
                        else nphase_in = NP_AFTER;
                     end
                  end
                  FK_F: begin
                     if (nphase_ff == NP_BEGIN || nphase_ff == NP_SIGN) begin
                        if (cls.is_digit) begin
                           nphase_in = NP_DIGITS;
                           acc_in    = acc_next;
                        end else if (nphase_ff == NP_BEGIN && cls.is_space) begin
                           nphase_in = nphase_ff;
                        end else if (nphase_ff == NP_BEGIN && (cls.is_plus || cls.is_minus)) begin
                           nphase_in = NP_SIGN;
                           failed_in = cls.is_minus;
                        end else begin
                           nphase_in = NP_IGNORE;
                        end
                     end else if (nphase_ff == NP_DIGITS) begin
                        if (cls.is_digit) acc_in = acc_next;
                        else nphase_in = NP_AFTER;
                     end
                  end
                  FK_L: begin
                     if (nphase_ff == NP_BEGIN) begin
                        if (cls.is_digit) begin
                           nphase_in = NP_DIGITS;
                           acc_in    = acc_next;
                        end else if (!cls.is_space) begin
                           fail = 1'b1;
                        end
                     end else if (nphase_ff == NP_DIGITS) begin
                        if (cls.is_digit) begin
                           acc_in = acc_next;
                        end else begin
                           baddr_in  = acc_ff;
                           nphase_in = NP_AFTER;
                        end
                     end else if (cls.is_bit) begin
                        // one fuse bit
                        if (baddr_ff >= count_ff) begin
                           fail = 1'b1;
                        end else begin
                           ev       = EV_WRITE;
                           ev_addr  = baddr_ff;
                           ev_val   = bit_val;
                           baddr_in = baddr_ff + AW'(1);
                        end
                     end
                  end
                  default: begin
                     kind_in = kind_ff;
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase

      // format error drops back to waiting for the next file
      if (fail) begin
         ev       = EV_ERROR;
         phase_in = PH_WAIT;
      end
   end

   // result beat; count is reported as updated by this byte
   always_comb begin
      result.event_res    = ev;
      result.fuse_address = ADDR_W'(ev_addr);
      result.fuse_value   = ev_val;
      result.fuse_count   = COUNT_W'(count_in);
   end

   // state registers, advanced once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         kind_ff     <= FK_OTHER;
         nphase_ff   <= NP_BEGIN;
         acc_ff      <= '0;
         count_ff    <= '0;
         declared_ff <= 1'b0;
         baddr_ff    <= '0;
         failed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         nphase_ff   <= nphase_in;
         acc_ff      <= acc_in;
         count_ff    <= count_in;
         declared_ff <= declared_in;
         baddr_ff    <= baddr_in;
         failed_ff   <= failed_in;
      end
   end

   // checks
   `JFP_ASSERT(a_write_in_range, clock, reset, (step && ev == EV_WRITE) |-> (declared_ff && baddr_ff < count_ff), "fuse write outside declared count")
   `JFP_ASSERT(a_count_once, clock, reset, (step && ev == EV_COUNT) |=> (declared_ff && !$past(declared_ff)), "fuse count declared twice")
   `JFP_ASSERT(a_acc_capped, clock, reset, step |=> (acc_ff <= AW'(CAP)), "accumulator beyond saturation")
   `JFP_ASSERT_NEVER(a_error_stays, clock, reset, $past(step && (ev == EV_ERROR || ev == EV_DONE)) && phase_ff != PH_WAIT && !$past(reset), "parser not waiting after error or done")

endmodule
